@@ design/lka_pkg.sv @@
// Shared constants, types and helpers for the luma key alpha pipeline.
package lka_pkg;

	localparam int unsigned CH_W     = 8;
	localparam int unsigned LVL_W    = 10;
	localparam int unsigned SUM_W    = 16;
	localparam int unsigned NUM_W    = CH_W + LVL_W;
	localparam int unsigned Y_SHIFT  = 6;

	localparam logic [LVL_W-1:0] LUMA_FULL = 10'd1020;
	localparam logic [6:0]       WEIGHT_R  = 7'd77;
	localparam logic [7:0]       WEIGHT_G  = 8'd150;
	localparam logic [4:0]       WEIGHT_B  = 5'd29;

	localparam logic [LVL_W-1:0] THR_RESET  = 10'd102;
	localparam logic [LVL_W-1:0] SOFT_RESET = 10'd102;

	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_SOFTNESS  = 2'd1;
	localparam logic [1:0] REG_INVERT    = 2'd2;

	typedef enum logic [1:0] {
		MODE_CLEAR,
		MODE_RAMP,
		MODE_KEEP
	} key_mode_t;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [CH_W-1:0]  quo;
	} div_t;

	// one restoring step: subtract the shifted divisor when it fits
	function automatic div_t div_step(input div_t d, input logic [NUM_W-1:0] dsh);
		div_t r;
		if (d.rem >= dsh) begin
			r.rem = d.rem - dsh;
			r.quo = {d.quo[CH_W-2:0], 1'b1};
		end else begin
			r.rem = d.rem;
			r.quo = {d.quo[CH_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

@@ design/luma_key_alpha_core.sv @@
// Luma key with soft threshold: BGRA pixel in, colour passed, alpha keyed.
// The start strobe passes through the stage valid bits vld_s1 to vld_s8 and leaves as the done strobe.
// Throughput: one beat per clock; busy is always low, each stage registers per clock.
// The ramp division runs as a restoring divider spread over four stages, two bits each.
// Reset clears the stage valid bits and loads threshold 102, softness 102, no invert.
// The receiver cannot stall, so results leave straight from the last stage.
module luma_key_alpha_core
	import lka_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [CH_W-1:0]  blue_in,
	input  logic [CH_W-1:0]  green_in,
	input  logic [CH_W-1:0]  red_in,
	input  logic [CH_W-1:0]  alpha_in,
	output logic             done,
	output logic [CH_W-1:0]  blue_out,
	output logic [CH_W-1:0]  green_out,
	output logic [CH_W-1:0]  red_out,
	output logic [CH_W-1:0]  alpha_out,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [LVL_W-1:0] cfg_data
);

	// Configuration registers. Writes must only arrive while the pipe is empty; the block
	// itself does not enforce it. Stages 2, 3 and 5 to 8 read these directly.
	logic [LVL_W-1:0] thr_q;
	logic [LVL_W-1:0] soft_q;
	logic             inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			soft_q <= SOFT_RESET;
			inv_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: thr_q  <= cfg_data;
				REG_SOFTNESS:  soft_q <= cfg_data;
				REG_INVERT:    inv_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Never stalls: a beat may enter on every clock.
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// Valid bits travel alongside the data, one per stage.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// Colour rides along every stage untouched; the incoming alpha rides along up to stage 7.
	logic [CH_W-1:0] b_s1, g_s1, r_s1, a_s1;
	logic [CH_W-1:0] b_s2, g_s2, r_s2, a_s2;
	logic [CH_W-1:0] b_s3, g_s3, r_s3, a_s3;
	logic [CH_W-1:0] b_s4, g_s4, r_s4, a_s4;
	logic [CH_W-1:0] b_s5, g_s5, r_s5, a_s5;
	logic [CH_W-1:0] b_s6, g_s6, r_s6, a_s6;
	logic [CH_W-1:0] b_s7, g_s7, r_s7, a_s7;
	logic [CH_W-1:0] b_s8, g_s8, r_s8;

	// Stage 1: weighted luma sum (constant multiplies and adds).
	logic [SUM_W-1:0] sum_s1;

	// Stage 2: quarter-step luma turned into the key distance.
	logic [LVL_W-1:0] dist_s2;

	// Stage 3: classify against the ramp and form the ramp offset.
	key_mode_t        mode_s3, mode_s4, mode_s5, mode_s6, mode_s7;
	logic [LVL_W-1:0] diff_s3;

	// Stage 4: ramp numerator alpha * offset.
	logic [NUM_W-1:0] num_s4;

	// Stages 5..8: restoring divider, two quotient bits per stage.
	div_t div_s5, div_s6, div_s7;
	logic [CH_W-1:0] alpha_s8;

	logic [SUM_W-1:0] sum_d;
	logic [LVL_W-1:0] y4_d;
	logic [LVL_W:0]   ramp_end_d;
	key_mode_t        mode_d;
	logic [NUM_W-1:0] soft_ext;
	div_t             div5_d, div6_d, div7_d, div8_d;

	assign sum_d = SUM_W'(WEIGHT_R * red_in)
		+ SUM_W'(WEIGHT_G * green_in)
		+ SUM_W'(WEIGHT_B * blue_in);

	assign y4_d = sum_s1[Y_SHIFT +: LVL_W];

	// Ramp end kept one bit wider so it never wraps past full scale.
	assign ramp_end_d = {1'b0, thr_q} + {1'b0, soft_q};

	always_comb begin
		if (dist_s2 <= thr_q) begin
			mode_d = MODE_CLEAR;
		end else if ({1'b0, dist_s2} < ramp_end_d) begin
			mode_d = MODE_RAMP;
		end else begin
			mode_d = MODE_KEEP;
		end
	end

	assign soft_ext = NUM_W'(soft_q);

	// Quotient is below 256 in the ramp, so eight steps from bit 7 suffice.
	always_comb begin
		div5_d = div_step(div_step(div_t'{rem: num_s4, quo: '0}, soft_ext << 7),
			soft_ext << 6);
		div6_d = div_step(div_step(div_s5, soft_ext << 5), soft_ext << 4);
		div7_d = div_step(div_step(div_s6, soft_ext << 3), soft_ext << 2);
		div8_d = div_step(div_step(div_s7, soft_ext << 1), soft_ext);
	end

	always_ff @(posedge clk) begin
		// stage 1
		b_s1   <= blue_in;
		g_s1   <= green_in;
		r_s1   <= red_in;
		a_s1   <= alpha_in;
		sum_s1 <= sum_d;
		// stage 2
		b_s2    <= b_s1;
		g_s2    <= g_s1;
		r_s2    <= r_s1;
		a_s2    <= a_s1;
		dist_s2 <= inv_q ? (LUMA_FULL - y4_d) : y4_d;
		// stage 3
		b_s3    <= b_s2;
		g_s3    <= g_s2;
		r_s3    <= r_s2;
		a_s3    <= a_s2;
		mode_s3 <= mode_d;
		diff_s3 <= dist_s2 - thr_q;
		// stage 4
		b_s4    <= b_s3;
		g_s4    <= g_s3;
		r_s4    <= r_s3;
		a_s4    <= a_s3;
		mode_s4 <= mode_s3;
		num_s4  <= NUM_W'(a_s3 * diff_s3);
		// stage 5
		b_s5    <= b_s4;
		g_s5    <= g_s4;
		r_s5    <= r_s4;
		a_s5    <= a_s4;
		mode_s5 <= mode_s4;
		div_s5  <= div5_d;
		// stage 6
		b_s6    <= b_s5;
		g_s6    <= g_s5;
		r_s6    <= r_s5;
		a_s6    <= a_s5;
		mode_s6 <= mode_s5;
		div_s6  <= div6_d;
		// stage 7
		b_s7    <= b_s6;
		g_s7    <= g_s6;
		r_s7    <= r_s6;
		a_s7    <= a_s6;
		mode_s7 <= mode_s6;
		div_s7  <= div7_d;
		// stage 8: pick the final alpha and hold the beat for one cycle
		b_s8 <= b_s7;
		g_s8 <= g_s7;
		r_s8 <= r_s7;
		unique case (mode_s7)
			MODE_CLEAR: alpha_s8 <= '0;
			MODE_RAMP:  alpha_s8 <= div8_d.quo;
			MODE_KEEP:  alpha_s8 <= a_s7;
			default:    alpha_s8 <= a_s7;
		endcase
	end

	assign done      = vld_s8;
	assign blue_out  = b_s8;
	assign green_out = g_s8;
	assign red_out   = r_s8;
	assign alpha_out = alpha_s8;

endmodule
